// ===== rtl/core/sme_pkg.sv =====
// shared types, opcodes and status codes for the stack machine executor
// no dependencies
`timescale 1ns / 1ps
package sme_pkg;

  localparam int StackDepth = 256;
  localparam int AddrW = $clog2(StackDepth);
  localparam int CountW = $clog2(StackDepth + 1);

  localparam logic [7:0] OP_PUSH = 8'h01;
  localparam logic [7:0] OP_ADD  = 8'h10;
  localparam logic [7:0] OP_SUB  = 8'h11;
  localparam logic [7:0] OP_MUL  = 8'h12;
  localparam logic [7:0] OP_DIV  = 8'h13;
  localparam logic [7:0] OP_MOD  = 8'h14;
  localparam logic [7:0] OP_NEG  = 8'h15;
  localparam logic [7:0] OP_AND  = 8'h16;
  localparam logic [7:0] OP_OR   = 8'h17;
  localparam logic [7:0] OP_XOR  = 8'h18;
  localparam logic [7:0] OP_NOT  = 8'h19;
  localparam logic [7:0] OP_SHL  = 8'h1A;
  localparam logic [7:0] OP_SAR  = 8'h1B;
  localparam logic [7:0] OP_SHR  = 8'h1C;
  localparam logic [7:0] OP_EMIT = 8'h20;
  localparam logic [7:0] OP_DUP  = 8'h21;
  localparam logic [7:0] OP_DROP = 8'h22;
  localparam logic [7:0] OP_SWAP = 8'h23;
  localparam logic [7:0] OP_OVER = 8'h24;
  localparam logic [7:0] OP_EQ   = 8'h40;
  localparam logic [7:0] OP_NE   = 8'h41;
  localparam logic [7:0] OP_LT   = 8'h42;
  localparam logic [7:0] OP_LE   = 8'h43;
  localparam logic [7:0] OP_GT   = 8'h44;
  localparam logic [7:0] OP_GE   = 8'h45;
  localparam logic [7:0] OP_HALT = 8'hFF;

  localparam logic [2:0] ST_DONE    = 3'd0;
  localparam logic [2:0] ST_PRINTED = 3'd1;
  localparam logic [2:0] ST_HALTED  = 3'd2;
  localparam logic [2:0] ST_DIVZERO = 3'd3;
  localparam logic [2:0] ST_FAULT   = 3'd4;
  localparam logic [2:0] ST_BADOP   = 3'd5;
  localparam logic [2:0] ST_IGNORED = 3'd6;

  typedef struct packed {
    logic [7:0]         cmd;
    logic signed [31:0] operand;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] value;
    logic [8:0]         depth;
  } out_word_t;

  // decoded instruction handed from front to back
  typedef struct packed {
    logic [7:0]  cmd;
    logic [31:0] operand;
    logic [1:0]  need;
    logic        grow;
    logic        shrink;
    logic        known;
  } dec_t;

endpackage

// ===== rtl/core/stack_machine_executor_unit.sv =====
// Stack machine executor, top level: one result word per instruction word.
// A decoded instruction queue of two entries sits between the input side and the
// executing back end. The back end runs an instruction only while its one-word
// result register is empty, and that register empties on the edge the word is
// popped, so a new instruction issues only after the previous result word is taken;
// an accepted word is registered in the queue, then its result in the result register.
// Instructions that pop (binary ops, print, drop) refill the next-lower entry from
// the stack memory in the following cycle, which overlaps that pop and costs nothing
// extra. Divide and modulo occupy the back end for the 32 steps of the
// 1-bit-per-cycle iterative divider plus start, finish and the pop. Holding pop
// low while a word waits stalls the back end.
// Depends on sme_pkg, sme_front, sme_back, sme_div.
`timescale 1ns / 1ps
module stack_machine_executor_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  sme_pkg::in_word_t  in_word,
  output logic               empty,
  input  logic               pop,
  output sme_pkg::out_word_t out_word
);
  import sme_pkg::*;

  logic dec_valid, dec_take;
  dec_t dec;

  sme_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_word(in_word),
    .dec_valid(dec_valid), .dec(dec), .dec_take(dec_take)
  );

  sme_back u_back (
    .clk(clk), .rst(rst), .dec_valid(dec_valid), .dec(dec), .dec_take(dec_take),
    .empty(empty), .pop(pop), .out_word(out_word)
  );
endmodule

// ===== rtl/core/sme_front.sv =====
// front end: accepts words, decodes opcodes into a two-entry queue
// depends on sme_pkg
`timescale 1ns / 1ps
module sme_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  sme_pkg::in_word_t in_word,
  output logic             dec_valid,
  output sme_pkg::dec_t    dec,
  input  logic             dec_take
);
  import sme_pkg::*;

  dec_t q [2];
  logic rd_ptr, wr_ptr;
  logic [1:0] cnt;
  dec_t d;

  always_comb begin
    d = '0;
    d.cmd = in_word.cmd;
    d.operand = in_word.operand;
    d.known = 1'b1;
    unique case (in_word.cmd)
      OP_PUSH: d.grow = 1'b1;
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_AND, OP_OR, OP_XOR, OP_SHL, OP_SAR,
      OP_SHR, OP_EQ, OP_NE, OP_LT, OP_LE, OP_GT, OP_GE: begin
        d.need = 2'd2;
        d.shrink = 1'b1;
      end
      OP_NEG, OP_NOT: d.need = 2'd1;
      OP_EMIT, OP_DROP: begin
        d.need = 2'd1;
        d.shrink = 1'b1;
      end
      OP_DUP: begin
        d.need = 2'd1;
        d.grow = 1'b1;
      end
      OP_SWAP: d.need = 2'd2;
      OP_OVER: begin
        d.need = 2'd2;
        d.grow = 1'b1;
      end
      OP_HALT: d.need = 2'd0;
      default: d.known = 1'b0;
    endcase
  end

  assign full = cnt == 2'd2;
  assign dec_valid = cnt != 2'd0;
  assign dec = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) q[wr_ptr] <= d;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      cnt <= '0;
    end else begin
      if (push && !full) wr_ptr <= !wr_ptr;
      if (dec_take && dec_valid) rd_ptr <= !rd_ptr;
      cnt <= cnt + 2'((push && !full) ? 1 : 0) - 2'((dec_take && dec_valid) ? 1 : 0);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= 2'd2)
    else $error("queue count out of range");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd0) |-> !dec_valid) else $error("valid while empty");
  a_ptrs: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd0 || cnt == 2'd2) |-> (rd_ptr == wr_ptr)) else $error("pointer mismatch");
endmodule

// ===== rtl/core/sme_div.sv =====
// iterative signed divider, one quotient bit per cycle
// depends on sme_pkg
`timescale 1ns / 1ps
module sme_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        busy,
  output logic        done,
  output logic [31:0] quo,
  output logic [31:0] rem
);
  import sme_pkg::*;

  logic [31:0] dvd, dvs, q;
  logic [32:0] r;
  logic [5:0]  step;
  logic        an, qn;
  logic [32:0] r_sh, r_sub;

  assign r_sh = {r[31:0], dvd[31]};
  assign r_sub = r_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= 6'd32;
      end else if (busy) begin
        step <= step - 6'd1;
        if (step == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= a[31] ? 32'd0 - a : a;
      dvs <= b[31] ? 32'd0 - b : b;
      an <= a[31];
      qn <= a[31] ^ b[31];
      r <= '0;
      q <= '0;
    end else if (busy) begin
      dvd <= {dvd[30:0], 1'b0};
      if (!r_sub[32]) begin
        r <= r_sub;
        q <= {q[30:0], 1'b1};
      end else begin
        r <= r_sh;
        q <= {q[30:0], 1'b0};
      end
    end
  end

  assign quo = qn ? 32'd0 - q : q;
  assign rem = an ? 32'd0 - r[31:0] : r[31:0];

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("done without busy");
  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("start while busy");
endmodule

// ===== rtl/core/sme_back.sv =====
// back end: stack memory, top-of-stack registers, alu, result register
// depends on sme_pkg and sme_div
`timescale 1ns / 1ps
module sme_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              dec_valid,
  input  sme_pkg::dec_t     dec,
  output logic              dec_take,
  output logic              empty,
  input  logic              pop,
  output sme_pkg::out_word_t out_word
);
  import sme_pkg::*;

  typedef enum logic [3:0] {
    S_RUN  = 4'b0001,
    S_FILL = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  // top two entries live in registers, deeper entries in memory
  logic [31:0] mem [StackDepth];
  logic [31:0] t, u, rd_data;
  logic [CountW-1:0] count;
  logic stopped;
  state_t state;
  logic [7:0] div_cmd;

  logic div_start, div_busy, div_done;
  logic [31:0] quo, rem;

  logic out_full;
  out_word_t res;

  logic fault;
  logic [31:0] r;
  logic [CountW:0] new_cnt;

  sme_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .a(u), .b(t),
    .busy(div_busy), .done(div_done), .quo(quo), .rem(rem)
  );

  assign new_cnt = {1'b0, count} - (CountW+1)'(dec.shrink) + (CountW+1)'(dec.grow);
  assign fault = ({1'b0, count} < (CountW+1)'(dec.need)) || (new_cnt > (CountW+1)'(StackDepth));

  always_comb begin
    unique case (dec.cmd)
      OP_ADD: r = u + t;
      OP_SUB: r = u - t;
      OP_MUL: r = u * t;
      OP_AND: r = u & t;
      OP_OR:  r = u | t;
      OP_XOR: r = u ^ t;
      OP_SHL: r = u << t[4:0];
      OP_SAR: r = 32'($signed(u) >>> t[4:0]);
      OP_SHR: r = u >> t[4:0];
      OP_EQ:  r = {31'd0, u == t};
      OP_NE:  r = {31'd0, u != t};
      OP_LT:  r = {31'd0, $signed(u) < $signed(t)};
      OP_LE:  r = {31'd0, $signed(u) <= $signed(t)};
      OP_GT:  r = {31'd0, $signed(u) > $signed(t)};
      OP_GE:  r = {31'd0, $signed(u) >= $signed(t)};
      default: r = '0;
    endcase
  end

  // an item runs only in S_RUN with the result register free;
  // a divide leaves the queue when the divider finishes
  assign dec_take = ((state == S_RUN) && dec_valid && !out_full &&
                     !(!stopped && dec.known && !fault && dec.cmd != OP_HALT &&
                       (dec.cmd == OP_DIV || dec.cmd == OP_MOD) && t != 32'd0)) ||
                    ((state == S_DIV) && div_done);
  assign div_start = (state == S_RUN) && dec_valid && !out_full && !dec_take;

  assign empty = !out_full;
  assign out_word = res;

  // memory write and a registered read of the entry below u
  logic        mem_we;
  logic [AddrW-1:0] mem_wa, mem_ra;
  logic [31:0] mem_wd;
  logic [CountW-1:0] count_next;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_data <= mem[mem_ra];
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = u;
    mem_ra = AddrW'(count - CountW'(3));
    count_next = count;
    if (dec_take && !stopped && dec.known && dec.cmd != OP_HALT && !fault) begin
      count_next = new_cnt[CountW-1:0];
      if (dec.grow) begin
        // u spills to memory at position count-2
        mem_we = count >= CountW'(2);
        mem_wa = AddrW'(count - CountW'(2));
      end
    end
    if (state == S_DIV && div_done) count_next = count - CountW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RUN;
      count <= '0;
      stopped <= 1'b0;
      out_full <= 1'b0;
    end else begin
      if (pop && out_full) out_full <= 1'b0;
      count <= count_next;
      unique case (state)
        S_RUN: begin
          if (div_start) begin
            state <= S_DIV;
            div_cmd <= dec.cmd;
          end else if (dec_take) begin
            out_full <= 1'b1;
            res.value <= '0;
            res.depth <= 9'(count_next);
            if (stopped) res.status <= ST_IGNORED;
            else if (!dec.known) res.status <= ST_BADOP;
            else if (dec.cmd == OP_HALT) begin
              res.status <= ST_HALTED;
              stopped <= 1'b1;
            end else if (fault) res.status <= ST_FAULT;
            else begin
              res.status <= ST_DONE;
              if (dec.shrink && new_cnt >= (CountW+1)'(2)) state <= S_FILL;
              priority case (1'b1)
                dec.cmd == OP_PUSH: begin
                  u <= t;
                  t <= dec.operand;
                end
                dec.cmd == OP_DUP: u <= t;
                dec.cmd == OP_OVER: begin
                  u <= t;
                  t <= u;
                end
                dec.cmd == OP_SWAP: begin
                  u <= t;
                  t <= u;
                end
                dec.cmd == OP_NEG: t <= 32'd0 - t;
                dec.cmd == OP_NOT: t <= ~t;
                dec.cmd == OP_EMIT || dec.cmd == OP_DROP: begin
                  if (dec.cmd == OP_EMIT) begin
                    res.status <= ST_PRINTED;
                    res.value <= t;
                  end
                  t <= u;
                end
                dec.cmd == OP_DIV || dec.cmd == OP_MOD: begin
                  // divide by zero: divisor popped, block stops
                  res.status <= ST_DIVZERO;
                  stopped <= 1'b1;
                  t <= u;
                end
                default: t <= r;
              endcase
            end
          end
        end
        S_FILL: begin
          u <= rd_data;
          state <= S_RUN;
        end
        S_DIV: begin
          if (div_done) begin
            t <= (div_cmd == OP_DIV) ? quo : rem;
            out_full <= 1'b1;
            res.status <= ST_DONE;
            res.value <= '0;
            res.depth <= 9'(count_next);
            state <= (count >= CountW'(3)) ? S_FILL : S_RUN;
          end
        end
        S_OUT: state <= S_RUN;
        default: state <= S_RUN;
      endcase
    end
  end

  // the fill uses the word read at count-3 before the pop
  a_fill_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL) |=> (state == S_RUN)) else $error("fill stuck");
  a_take_needs_room: assert property (@(posedge clk) disable iff (rst)
    dec_take |-> !out_full) else $error("take with full result");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CountW'(StackDepth)) else $error("stack count overflow");
  a_div_one_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && div_busy) |-> !dec_take) else $error("take during divide");
endmodule
